// ----- rtl/bale_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the array list engine.
package bale_pkg;

    // List geometry
    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the stream payloads
    localparam int ACT_W    = 3;
    localparam int POS_W    = 4;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int FILL_W   = 4;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 1 + VAL_W + FILL_W + 1 + 1;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_FRONT  = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_SEARCH = 3'd4,
        ACT_SORT   = 3'd5,
        ACT_READ   = 3'd6,
        ACT_NOP    = 3'd7
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_MISSING   = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    // One datapath micro-operation per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_INS_INIT,
        OP_SCAN_INIT,
        OP_SORT_INIT,
        OP_RD_POS,
        OP_RD_CAPTURE,
        OP_RD_KM1,
        OP_WR_K_SHIFT,
        OP_INS_PUT,
        OP_RD_K,
        OP_K_INC,
        OP_RD_K1,
        OP_DEL_WR,
        OP_DEL_DONE,
        OP_RD_I,
        OP_HOLD_LD,
        OP_RD_J,
        OP_SORT_CMP,
        OP_SORT_PUT
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP_RD,
        S_SHIFT_UP_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_SORT_I_RD,
        S_SORT_I_LD,
        S_SORT_J_RD,
        S_SORT_J_CMP,
        S_READ_WAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_dp_op  op;
        logic    status_set;
        t_status status;
        logic    found_set;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    full;
        logic    pos_gt_cnt;
        logic    pos_ge_cnt;
        logic    k_gt_tgt;
        logic    k_lt_cnt;
        logic    k1_lt_cnt;
        logic    i_lt_cnt;
        logic    j_lt_cnt;
        logic    match;
    } t_dp_stat;

    typedef struct packed {
        t_status           status;
        logic              found;
        logic [VAL_W-1:0]  read_value;
        logic [FILL_W-1:0] fill_count;
        logic              is_full;
        logic              is_empty;
    } t_result;

endpackage

// ----- rtl/bale_datapath.sv -----
// Datapath: entry memory, fill count, index counters, compare logic and result register.
module bale_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [bale_pkg::ACT_W-1:0] i_action,
    input  logic [bale_pkg::POS_W-1:0] i_pos,
    input  logic [bale_pkg::VAL_W-1:0] i_value,
    input  bale_pkg::t_dp_cmd         i_cmd,
    output bale_pkg::t_dp_stat        o_stat,
    output bale_pkg::t_result         o_result
);

    localparam int CNT_W = bale_pkg::CNT_W;
    localparam int IDX_W = bale_pkg::IDX_W;
    localparam int CMP_W = bale_pkg::CMP_W;
    localparam int VAL_W = bale_pkg::VAL_W;

    // Entry memory, no reset: entries above the count are never read
    logic [VAL_W-1:0] r_mem [bale_pkg::CAPACITY];
    logic [VAL_W-1:0] r_rdata;

    bale_pkg::t_action      r_action;
    logic [bale_pkg::POS_W-1:0] r_pos;
    logic [VAL_W-1:0]       r_value;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_k;
    logic [CNT_W-1:0]       r_i;
    logic [CNT_W-1:0]       r_j;
    logic [CNT_W-1:0]       r_tgt;
    logic [VAL_W-1:0]       r_hold;
    bale_pkg::t_status      r_status;
    logic                   r_found;
    logic [VAL_W-1:0]       r_rd;
    bale_pkg::t_result      r_result;

    logic [CMP_W-1:0]       pos_x;
    logic [CMP_W-1:0]       count_x;
    logic [CNT_W-1:0]       k_m1;
    logic [CNT_W-1:0]       k_p1;
    logic [CNT_W:0]         k_p1_wide;
    logic                   greater;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [VAL_W-1:0]       wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [CNT_W-1:0]       tgt_sel;

    // Comparisons and neighbouring indexes
    assign pos_x     = CMP_W'(r_pos);
    assign count_x   = CMP_W'(r_count);
    assign k_m1      = r_k - 1'b1;
    assign k_p1_wide = (CNT_W+1)'(r_k) + (CNT_W+1)'(1);
    assign k_p1      = k_p1_wide[CNT_W-1:0];
    assign greater   = $signed(r_hold) > $signed(r_rdata);

    always_comb begin
        o_stat.action     = r_action;
        o_stat.full       = (r_count == CNT_W'(bale_pkg::CAPACITY));
        o_stat.pos_gt_cnt = (pos_x > count_x);
        o_stat.pos_ge_cnt = (pos_x >= count_x);
        o_stat.k_gt_tgt   = (r_k > r_tgt);
        o_stat.k_lt_cnt   = (r_k < r_count);
        o_stat.k1_lt_cnt  = (k_p1_wide < (CNT_W+1)'(r_count));
        o_stat.i_lt_cnt   = (r_i < r_count);
        o_stat.j_lt_cnt   = (r_j < r_count);
        o_stat.match      = (r_rdata == r_value);
    end

    // Insert target: the end for append, zero for front, the given index otherwise
    always_comb begin
        case (r_action)
            bale_pkg::ACT_APPEND: tgt_sel = r_count;
            bale_pkg::ACT_FRONT:  tgt_sel = '0;
            default:              tgt_sel = CNT_W'(r_pos);
        endcase
    end

    // Memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_k[IDX_W-1:0];
        wr_data = r_rdata;
        rd_en   = 1'b0;
        rd_addr = r_k[IDX_W-1:0];
        case (i_cmd.op)
            bale_pkg::OP_RD_POS: begin
                rd_en   = 1'b1;
                rd_addr = pos_x[IDX_W-1:0];
            end
            bale_pkg::OP_RD_KM1: begin
                rd_en   = 1'b1;
                rd_addr = k_m1[IDX_W-1:0];
            end
            bale_pkg::OP_RD_K: begin
                rd_en   = 1'b1;
            end
            bale_pkg::OP_RD_K1: begin
                rd_en   = 1'b1;
                rd_addr = k_p1[IDX_W-1:0];
            end
            bale_pkg::OP_RD_I: begin
                rd_en   = 1'b1;
                rd_addr = r_i[IDX_W-1:0];
            end
            bale_pkg::OP_RD_J: begin
                rd_en   = 1'b1;
                rd_addr = r_j[IDX_W-1:0];
            end
            bale_pkg::OP_WR_K_SHIFT, bale_pkg::OP_DEL_WR: begin
                wr_en   = 1'b1;
            end
            bale_pkg::OP_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_tgt[IDX_W-1:0];
                wr_data = r_value;
            end
            bale_pkg::OP_SORT_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_i[IDX_W-1:0];
                wr_data = r_hold;
            end
            bale_pkg::OP_SORT_CMP: begin
                wr_en   = greater;
                wr_addr = r_j[IDX_W-1:0];
                wr_data = r_hold;
            end
            default: begin
                wr_en   = 1'b0;
            end
        endcase
    end

    // Memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.op == bale_pkg::OP_INS_PUT) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.op == bale_pkg::OP_DEL_DONE) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Request capture, counters and working register
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bale_pkg::OP_LATCH: begin
                r_action <= bale_pkg::t_action'(i_action);
                r_pos    <= i_pos;
                r_value  <= i_value;
            end
            bale_pkg::OP_INS_INIT: begin
                r_k   <= r_count;
                r_tgt <= tgt_sel;
            end
            bale_pkg::OP_SCAN_INIT:  r_k <= '0;
            bale_pkg::OP_WR_K_SHIFT: r_k <= k_m1;
            bale_pkg::OP_K_INC:      r_k <= k_p1;
            bale_pkg::OP_DEL_WR:     r_k <= k_p1;
            bale_pkg::OP_SORT_INIT:  r_i <= '0;
            bale_pkg::OP_HOLD_LD: begin
                r_hold <= r_rdata;
                r_j    <= r_i + 1'b1;
            end
            bale_pkg::OP_SORT_CMP: begin
                if (greater) begin
                    r_hold <= r_rdata;
                end
                r_j <= r_j + 1'b1;
            end
            bale_pkg::OP_SORT_PUT: r_i <= r_i + 1'b1;
            default: begin
            end
        endcase
    end

    // Outcome of the current request
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bale_pkg::OP_LATCH) begin
            r_status <= bale_pkg::ST_OK;
            r_found  <= 1'b0;
            r_rd     <= '0;
        end else begin
            if (i_cmd.status_set) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.found_set) begin
                r_found <= 1'b1;
            end
            if (i_cmd.op == bale_pkg::OP_RD_CAPTURE) begin
                r_rd <= r_rdata;
            end
        end
    end

    // Result register towards the output stream
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result.status     <= r_status;
            r_result.found      <= r_found;
            r_result.read_value <= r_rd;
            r_result.fill_count <= bale_pkg::FILL_W'(r_count);
            r_result.is_full    <= (r_count == CNT_W'(bale_pkg::CAPACITY));
            r_result.is_empty   <= (r_count == '0);
        end
    end

    assign o_result = r_result;

endmodule

// ----- rtl/bale_controller.sv -----
// Controller: sequences each request through datapath micro-operations and owns the handshakes.
module bale_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  bale_pkg::t_dp_stat i_stat,
    output bale_pkg::t_dp_cmd  o_cmd
);

    bale_pkg::t_state r_state;
    bale_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             slot_free;

    assign o_in_ready  = (r_state == bale_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign slot_free   = !r_out_valid || i_out_ready;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bale_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        o_cmd.op         = bale_pkg::OP_NONE;
        o_cmd.status_set = 1'b0;
        o_cmd.status     = bale_pkg::ST_OK;
        o_cmd.found_set  = 1'b0;
        o_cmd.out_load   = 1'b0;
        n_out_valid      = r_out_valid && !i_out_ready;
        case (r_state)
            bale_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = bale_pkg::OP_LATCH;
                    n_state  = bale_pkg::S_DECODE;
                end
            end
            bale_pkg::S_DECODE: begin
                case (i_stat.action)
                    bale_pkg::ACT_APPEND, bale_pkg::ACT_INSERT, bale_pkg::ACT_FRONT: begin
                        if (i_stat.full) begin
                            o_cmd.status_set = 1'b1;
                            o_cmd.status     = bale_pkg::ST_FULL;
                            n_state          = bale_pkg::S_FINISH;
                        end else if (i_stat.action == bale_pkg::ACT_INSERT &&
                                     i_stat.pos_gt_cnt) begin
                            o_cmd.status_set = 1'b1;
                            o_cmd.status     = bale_pkg::ST_BAD_INDEX;
                            n_state          = bale_pkg::S_FINISH;
                        end else begin
                            o_cmd.op = bale_pkg::OP_INS_INIT;
                            n_state  = bale_pkg::S_SHIFT_UP_RD;
                        end
                    end
                    bale_pkg::ACT_DELETE, bale_pkg::ACT_SEARCH: begin
                        o_cmd.op = bale_pkg::OP_SCAN_INIT;
                        n_state  = bale_pkg::S_SCAN_RD;
                    end
                    bale_pkg::ACT_SORT: begin
                        o_cmd.op = bale_pkg::OP_SORT_INIT;
                        n_state  = bale_pkg::S_SORT_I_RD;
                    end
                    bale_pkg::ACT_READ: begin
                        if (i_stat.pos_ge_cnt) begin
                            o_cmd.status_set = 1'b1;
                            o_cmd.status     = bale_pkg::ST_BAD_INDEX;
                            n_state          = bale_pkg::S_FINISH;
                        end else begin
                            o_cmd.op = bale_pkg::OP_RD_POS;
                            n_state  = bale_pkg::S_READ_WAIT;
                        end
                    end
                    default: begin
                        n_state = bale_pkg::S_FINISH;
                    end
                endcase
            end
            // Move entries up one place, from the top down to the target
            bale_pkg::S_SHIFT_UP_RD: begin
                if (i_stat.k_gt_tgt) begin
                    o_cmd.op = bale_pkg::OP_RD_KM1;
                    n_state  = bale_pkg::S_SHIFT_UP_WR;
                end else begin
                    o_cmd.op = bale_pkg::OP_INS_PUT;
                    n_state  = bale_pkg::S_FINISH;
                end
            end
            bale_pkg::S_SHIFT_UP_WR: begin
                o_cmd.op = bale_pkg::OP_WR_K_SHIFT;
                n_state  = bale_pkg::S_SHIFT_UP_RD;
            end
            // Linear search for the first equal entry
            bale_pkg::S_SCAN_RD: begin
                if (i_stat.k_lt_cnt) begin
                    o_cmd.op = bale_pkg::OP_RD_K;
                    n_state  = bale_pkg::S_SCAN_CMP;
                end else begin
                    o_cmd.status_set = 1'b1;
                    o_cmd.status     = bale_pkg::ST_MISSING;
                    n_state          = bale_pkg::S_FINISH;
                end
            end
            bale_pkg::S_SCAN_CMP: begin
                if (i_stat.match) begin
                    o_cmd.found_set = 1'b1;
                    if (i_stat.action == bale_pkg::ACT_DELETE) begin
                        n_state = bale_pkg::S_DEL_RD;
                    end else begin
                        n_state = bale_pkg::S_FINISH;
                    end
                end else begin
                    o_cmd.op = bale_pkg::OP_K_INC;
                    n_state  = bale_pkg::S_SCAN_RD;
                end
            end
            // Close the gap left by a deleted entry
            bale_pkg::S_DEL_RD: begin
                if (i_stat.k1_lt_cnt) begin
                    o_cmd.op = bale_pkg::OP_RD_K1;
                    n_state  = bale_pkg::S_DEL_WR;
                end else begin
                    o_cmd.op = bale_pkg::OP_DEL_DONE;
                    n_state  = bale_pkg::S_FINISH;
                end
            end
            bale_pkg::S_DEL_WR: begin
                o_cmd.op = bale_pkg::OP_DEL_WR;
                n_state  = bale_pkg::S_DEL_RD;
            end
            // Exchange sort: hold entry i, swap with each smaller later entry
            bale_pkg::S_SORT_I_RD: begin
                if (i_stat.i_lt_cnt) begin
                    o_cmd.op = bale_pkg::OP_RD_I;
                    n_state  = bale_pkg::S_SORT_I_LD;
                end else begin
                    n_state = bale_pkg::S_FINISH;
                end
            end
            bale_pkg::S_SORT_I_LD: begin
                o_cmd.op = bale_pkg::OP_HOLD_LD;
                n_state  = bale_pkg::S_SORT_J_RD;
            end
            bale_pkg::S_SORT_J_RD: begin
                if (i_stat.j_lt_cnt) begin
                    o_cmd.op = bale_pkg::OP_RD_J;
                    n_state  = bale_pkg::S_SORT_J_CMP;
                end else begin
                    o_cmd.op = bale_pkg::OP_SORT_PUT;
                    n_state  = bale_pkg::S_SORT_I_RD;
                end
            end
            bale_pkg::S_SORT_J_CMP: begin
                o_cmd.op = bale_pkg::OP_SORT_CMP;
                n_state  = bale_pkg::S_SORT_J_RD;
            end
            bale_pkg::S_READ_WAIT: begin
                o_cmd.op = bale_pkg::OP_RD_CAPTURE;
                n_state  = bale_pkg::S_FINISH;
            end
            // Hand the outcome over once the output register is free
            bale_pkg::S_FINISH: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = bale_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bale_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bounded_array_list_engine.sv -----
// Top level of the bounded array list engine: stream ports, controller and datapath.
//
// Requests arrive on the slave stream: tuser carries the action, tdata the
// position and value. Each request produces exactly one result on the master
// stream: tuser carries the status, tdata the found flag, read value, fill
// count and the full and empty flags.
// One request is worked on at a time; the slave side is ready only while the
// controller is idle. A result waits in the output register while the next
// request is taken in; it is overwritten only after being taken.
// Append, insert and insert front move each entry from the top down to the
// target up one place; search and delete scan from the front for the first
// equal entry; read fetches the entry at the position; sort holds each entry
// in turn against every later one. The entry memory has a single registered
// read port, one read and one write per step. Rejected requests touch no entry.
// Reset empties the list; entries themselves are not cleared. When the
// receiver stalls, a finished result holds and the block waits before
// loading the next one.
module bounded_array_list_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [3:0] position, [35:4] value, [39:36] zero
    input  logic [bale_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // [2:0] action
    input  logic [bale_pkg::ACT_W-1:0]         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [0] found, [32:1] read_value, [36:33] fill_count, [37] is_full,
    // [38] is_empty, [39] zero
    output logic [bale_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // [1:0] status
    output logic [bale_pkg::STAT_W-1:0]        o_m_axis_tuser
);

    bale_pkg::t_dp_cmd  cmd;
    bale_pkg::t_dp_stat stat;
    bale_pkg::t_result  result;

    bale_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bale_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_action (i_s_axis_tuser),
        .i_pos    (i_s_axis_tdata[bale_pkg::POS_W-1:0]),
        .i_value  (i_s_axis_tdata[bale_pkg::POS_W +: bale_pkg::VAL_W]),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (result)
    );

    // Result packing
    assign o_m_axis_tuser = result.status;
    assign o_m_axis_tdata = bale_pkg::OUT_TDATA_W'({result.is_empty, result.is_full,
                                                    result.fill_count, result.read_value,
                                                    result.found});

`ifndef NO_ASSERTIONS
    // A taken request keeps the slave side closed in the next cycle
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("slave side ready right after a request was taken");

    // The list can never be full and empty at once
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(result.is_full && result.is_empty))
        else $error("result reports full and empty together");

    // A full-list rejection is only reported when the list is full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && result.status == bale_pkg::ST_FULL) |-> result.is_full)
        else $error("full status on a list that is not full");

    // Fill count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (result.fill_count <= bale_pkg::FILL_W'(bale_pkg::CAPACITY)))
        else $error("fill count above capacity");
`endif

endmodule
